// ----- rtl/rba_pkg.sv -----
// Shared types and codes for the reference-counted block allocator.
`default_nettype none
package rba_pkg;

	localparam logic [1:0] REQ_ALLOC  = 2'd0;
	localparam logic [1:0] REQ_INCREF = 2'd1;
	localparam logic [1:0] REQ_FREE   = 2'd2;

	localparam logic [2:0] ST_OK            = 3'd0;
	localparam logic [2:0] ST_OUT_OF_BLOCKS = 3'd1;
	localparam logic [2:0] ST_BAD_ID        = 3'd2;
	localparam logic [2:0] ST_INCREF_FREE   = 3'd3;
	localparam logic [2:0] ST_OVER_RELEASE  = 3'd4;
	localparam logic [2:0] ST_TOO_LONG      = 3'd5;
	localparam logic [2:0] ST_REF_OVERFLOW  = 3'd6;

	// free stack control from the sequencer
	typedef struct packed {
		logic init;
		logic pop;
		logic push;
	} stk_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/rba_ram.sv -----
// Generic simple dual-port RAM, one write port, registered read.
`default_nettype none
module rba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   we,
	input  wire logic [AW-1:0]          waddr,
	input  wire logic [WIDTH-1:0]       wdata,
	input  wire logic [AW-1:0]          raddr,
	output logic      [WIDTH-1:0]       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/rba_free_stack.sv -----
// LIFO free stack of block ids with a fill mark standing in for the reset image.
`default_nettype none
module rba_free_stack #(
	parameter int BLOCK_TOTAL = 1024,
	localparam int IDW = $clog2(BLOCK_TOTAL),
	localparam int BW = $clog2(BLOCK_TOTAL + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rba_pkg::stk_cmd_t cmd,
	input  wire logic [BW-1:0]     biu,
	input  wire logic [IDW-1:0]    push_id,
	output logic      [IDW-1:0]    top_id,
	output logic      [BW-1:0]     count
);
	logic [BW-1:0]  fc_q;
	logic [BW-1:0]  mark_q;
	logic [IDW-1:0] rdata;
	logic           push_ok;

	// entries at or above the mark were pushed since init; below it the
	// entry still holds its initial value biu-1-index
	assign push_ok = cmd.push && (fc_q < BW'(BLOCK_TOTAL));

	rba_ram #(.WIDTH(IDW), .DEPTH(BLOCK_TOTAL)) u_ram (
		.clk   (clk),
		.we    (push_ok),
		.waddr (IDW'(fc_q)),
		.wdata (push_id),
		.raddr (IDW'(fc_q - BW'(1))),
		.rdata (rdata)
	);

	assign top_id = (fc_q > mark_q) ? rdata : IDW'(biu - fc_q);
	assign count  = fc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q   <= BW'(BLOCK_TOTAL);
			mark_q <= BW'(BLOCK_TOTAL);
		end else if (cmd.init) begin
			fc_q   <= biu;
			mark_q <= biu;
		end else if (cmd.pop) begin
			fc_q <= fc_q - BW'(1);
		end else if (push_ok) begin
			fc_q <= fc_q + BW'(1);
			if (fc_q < mark_q) begin
				mark_q <= fc_q;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/refcounted_block_allocator.sv -----
// Top level: request sequencer, reference count store and batch buffer.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | req_type alloc_count block_index batch_last
//  out     | output    | out_valid/out_stall | status out_block has_block run_last
//  cfg     | input     | cfg_valid/cfg_ready | blocks_in_use
//
// Allocate: accept, then per id a free stack RAM read and then an emit.
// Batch: each id in each pass takes a batch RAM read, a count RAM read and an update,
// the free range check only the first two; up to five passes (check, tally, test,
// tally clear, commit), then an emit.
// Reset and every config write sweep all BLOCK_TOTAL entries to zero the count RAM;
// no item is accepted during the sweep. A stalled output holds the sequencer.
`default_nettype none
module refcounted_block_allocator #(
	parameter int BLOCK_TOTAL = 1024,
	parameter int MAX_BATCH  = 64,
	parameter int REF_BITS   = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [6:0]  alloc_count,
	input  wire logic [9:0]  block_index,
	input  wire logic        batch_last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [9:0]       out_block,
	output logic             has_block,
	output logic             run_last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [10:0] blocks_in_use
);
	localparam int IDW = $clog2(BLOCK_TOTAL);
	localparam int BW  = $clog2(BLOCK_TOTAL + 1);
	localparam int TW  = $clog2(MAX_BATCH + 1);
	localparam int LW  = $clog2(MAX_BATCH + 2);
	localparam int AW  = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
	localparam int CW  = TW + REF_BITS;
	localparam int OW  = ((REF_BITS > TW) ? REF_BITS : TW) + 1;
	localparam int XW  = (BW > 10) ? BW : 10;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_A_RD, S_A_EMIT, S_B_RD, S_B_ID, S_B_OP, S_EMIT
	} state_t;

	typedef enum logic [2:0] {
		P_CHECK, P_FILL, P_TEST, P_UNTALLY, P_COMMIT
	} pass_t;

	state_t            state_q;
	pass_t             pass_q;
	logic [BW-1:0]     biu_q;
	logic [BW-1:0]     biu_in;
	logic [BW-1:0]     cfg_clamp;
	logic [IDW-1:0]    clr_q;
	logic [LW-1:0]     blen_q;
	logic [LW-1:0]     blen_nxt;
	logic [LW-1:0]     len_q;
	logic [LW-1:0]     i_q;
	logic              last_i;
	logic [6:0]        rem_q;
	logic              incref_q;
	logic              fail_q;
	logic [9:0]        id_q;
	logic [2:0]        st_q;
	logic [9:0]        who_q;
	logic              has_q;
	logic              in_acc;
	logic              cfg_fire;
	logic              out_free;
	logic              is_batch;

	logic [9:0]        bm_rdata;
	logic              bm_we;
	logic              cm_we;
	logic [IDW-1:0]    cm_waddr;
	logic [CW-1:0]     cm_wdata;
	logic [CW-1:0]     cm_rdata;
	logic [REF_BITS-1:0] cnt;
	logic [TW-1:0]     tally;
	logic [OW-1:0]     cnt_sum;
	logic              ovf;
	logic              over_rel;

	rba_pkg::stk_cmd_t stk_cmd;
	logic [IDW-1:0]    stk_top;
	logic [BW-1:0]     stk_count;

	// a config write takes the cycle, so the input holds off while one is offered
	assign in_stall  = (state_q != S_IDLE) || cfg_valid;
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign out_free  = !out_valid || !out_stall;
	assign is_batch  = (req_type == rba_pkg::REQ_INCREF) || (req_type == rba_pkg::REQ_FREE);

	always_comb begin
		if (blocks_in_use == 11'd0) begin
			cfg_clamp = BW'(1);
		end else if (32'(blocks_in_use) > BLOCK_TOTAL) begin
			cfg_clamp = BW'(BLOCK_TOTAL);
		end else begin
			cfg_clamp = BW'(blocks_in_use);
		end
	end
	assign biu_in = cfg_fire ? cfg_clamp : biu_q;

	assign blen_nxt = (32'(blen_q) <= MAX_BATCH) ? blen_q + LW'(1) : blen_q;
	assign last_i   = (i_q + LW'(1)) == len_q;

	// batch id buffer
	assign bm_we = in_acc && is_batch && (32'(blen_q) < MAX_BATCH);

	rba_ram #(.WIDTH(10), .DEPTH(MAX_BATCH)) u_batch (
		.clk   (clk),
		.we    (bm_we),
		.waddr (AW'(blen_q)),
		.wdata (block_index),
		.raddr (AW'(i_q)),
		.rdata (bm_rdata)
	);

	// count store: {batch tally, reference count}
	rba_ram #(.WIDTH(CW), .DEPTH(BLOCK_TOTAL)) u_counts (
		.clk   (clk),
		.we    (cm_we),
		.waddr (cm_waddr),
		.wdata (cm_wdata),
		.raddr (IDW'(bm_rdata)),
		.rdata (cm_rdata)
	);

	assign cnt      = cm_rdata[REF_BITS-1:0];
	assign tally    = cm_rdata[CW-1:REF_BITS];
	assign cnt_sum  = OW'(cnt) + OW'(tally);
	assign ovf      = cnt_sum > OW'({REF_BITS{1'b1}});
	assign over_rel = OW'(cnt) < OW'(tally);

	always_comb begin
		cm_we    = 1'b0;
		cm_waddr = IDW'(id_q);
		cm_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				cm_we    = 1'b1;
				cm_waddr = clr_q;
			end
			S_A_EMIT: begin
				cm_we    = out_free;
				cm_waddr = stk_top;
				cm_wdata = {TW'(0), REF_BITS'(1)};
			end
			S_B_OP: begin
				case (pass_q)
					P_FILL: begin
						cm_we    = 1'b1;
						cm_wdata = {tally + TW'(1), cnt};
					end
					P_UNTALLY: begin
						cm_we    = 1'b1;
						cm_wdata = {TW'(0), cnt};
					end
					P_COMMIT: begin
						cm_we    = 1'b1;
						cm_wdata = {TW'(0), incref_q ? cnt + REF_BITS'(1) : cnt - REF_BITS'(1)};
					end
					default: begin
						cm_we = 1'b0;
					end
				endcase
			end
			default: begin
				cm_we = 1'b0;
			end
		endcase
	end

	assign stk_cmd.init = cfg_fire;
	assign stk_cmd.pop  = (state_q == S_A_EMIT) && out_free;
	assign stk_cmd.push = (state_q == S_B_OP) && (pass_q == P_COMMIT) && !incref_q
		&& (cnt == REF_BITS'(1));

	rba_free_stack #(.BLOCK_TOTAL(BLOCK_TOTAL)) u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (stk_cmd),
		.biu     (biu_in),
		.push_id (IDW'(id_q)),
		.top_id  (stk_top),
		.count   (stk_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			pass_q    <= P_CHECK;
			biu_q     <= BW'(BLOCK_TOTAL);
			clr_q     <= '0;
			blen_q    <= '0;
			len_q     <= '0;
			i_q       <= '0;
			rem_q     <= '0;
			incref_q  <= 1'b0;
			fail_q    <= 1'b0;
			id_q      <= '0;
			st_q      <= rba_pkg::ST_OK;
			who_q     <= '0;
			has_q     <= 1'b0;
			out_valid <= 1'b0;
			status    <= rba_pkg::ST_OK;
			out_block <= '0;
			has_block <= 1'b0;
			run_last  <= 1'b0;
		end else begin
			if (!out_stall) begin
				out_valid <= 1'b0;
			end
			if (cfg_fire) begin
				biu_q   <= cfg_clamp;
				blen_q  <= '0;
				clr_q   <= '0;
				state_q <= S_CLEAR;
			end else begin
				case (state_q)
					S_CLEAR: begin
						clr_q <= clr_q + IDW'(1);
						if (clr_q == IDW'(BLOCK_TOTAL - 1)) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (in_acc) begin
							st_q  <= rba_pkg::ST_OK;
							who_q <= '0;
							has_q <= 1'b0;
							if (req_type == rba_pkg::REQ_ALLOC) begin
								if (alloc_count == 7'd0) begin
									state_q <= S_EMIT;
								end else if (32'(alloc_count) > MAX_BATCH) begin
									st_q    <= rba_pkg::ST_TOO_LONG;
									state_q <= S_EMIT;
								end else if (32'(alloc_count) > 32'(stk_count)) begin
									st_q    <= rba_pkg::ST_OUT_OF_BLOCKS;
									state_q <= S_EMIT;
								end else begin
									rem_q   <= alloc_count;
									state_q <= S_A_RD;
								end
							end else if (is_batch) begin
								blen_q <= blen_nxt;
								if (batch_last) begin
									blen_q <= '0;
									if (32'(blen_nxt) > MAX_BATCH) begin
										st_q    <= rba_pkg::ST_TOO_LONG;
										state_q <= S_EMIT;
									end else begin
										len_q    <= blen_nxt;
										incref_q <= (req_type == rba_pkg::REQ_INCREF);
										fail_q   <= 1'b0;
										pass_q   <= P_CHECK;
										i_q      <= '0;
										state_q  <= S_B_RD;
									end
								end
							end
						end
					end
					S_A_RD: begin
						// stack RAM read of the new top entry is issued here and lands in S_A_EMIT
						state_q <= S_A_EMIT;
					end
					S_A_EMIT: begin
						if (out_free) begin
							out_valid <= 1'b1;
							status    <= rba_pkg::ST_OK;
							out_block <= 10'(stk_top);
							has_block <= 1'b1;
							run_last  <= (rem_q == 7'd1);
							rem_q     <= rem_q - 7'd1;
							state_q   <= (rem_q == 7'd1) ? S_IDLE : S_A_RD;
						end
					end
					S_B_RD: begin
						state_q <= S_B_ID;
					end
					S_B_ID: begin
						id_q    <= bm_rdata;
						state_q <= S_B_OP;
						if (pass_q == P_CHECK) begin
							if (XW'(bm_rdata) >= XW'(biu_q)) begin
								st_q    <= rba_pkg::ST_BAD_ID;
								who_q   <= bm_rdata;
								has_q   <= 1'b1;
								state_q <= S_EMIT;
							end else if (!incref_q) begin
								if (last_i) begin
									pass_q  <= P_FILL;
									i_q     <= '0;
								end else begin
									i_q <= i_q + LW'(1);
								end
								state_q <= S_B_RD;
							end
						end
					end
					S_B_OP: begin
						if (pass_q == P_CHECK && cnt == '0) begin
							st_q    <= rba_pkg::ST_INCREF_FREE;
							who_q   <= id_q;
							has_q   <= 1'b1;
							state_q <= S_EMIT;
						end else if (pass_q == P_TEST && (incref_q ? ovf : over_rel)) begin
							st_q    <= incref_q ? rba_pkg::ST_REF_OVERFLOW
								: rba_pkg::ST_OVER_RELEASE;
							who_q   <= id_q;
							has_q   <= 1'b1;
							fail_q  <= 1'b1;
							pass_q  <= P_UNTALLY;
							i_q     <= '0;
							state_q <= S_B_RD;
						end else if (!last_i) begin
							i_q     <= i_q + LW'(1);
							state_q <= S_B_RD;
						end else begin
							i_q     <= '0;
							state_q <= S_B_RD;
							case (pass_q)
								P_CHECK:   pass_q <= P_FILL;
								P_FILL:    pass_q <= P_TEST;
								P_TEST:    pass_q <= P_UNTALLY;
								P_UNTALLY: begin
									if (fail_q) begin
										state_q <= S_EMIT;
									end else begin
										pass_q <= P_COMMIT;
									end
								end
								default: begin
									st_q    <= rba_pkg::ST_OK;
									who_q   <= '0;
									has_q   <= 1'b0;
									state_q <= S_EMIT;
								end
							endcase
						end
					end
					S_EMIT: begin
						if (out_free) begin
							out_valid <= 1'b1;
							status    <= st_q;
							out_block <= who_q;
							has_block <= has_q;
							run_last  <= 1'b1;
							state_q   <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

`ifndef SYNTH
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stk_count <= biu_q)
		else $error("free stack holds more ids than managed blocks");

	a_blen_sat: assert property (@(posedge clk) disable iff (!arst_n)
		32'(blen_q) <= MAX_BATCH + 1)
		else $error("batch length past saturation");

	a_free_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_B_OP && pass_q == P_COMMIT && !incref_q) |-> cnt != '0)
		else $error("free commit on a zero count");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_A_EMIT) |-> stk_count != '0)
		else $error("allocate pop from an empty stack");
`endif

endmodule
`default_nettype wire

// ----- bench/refcounted_block_allocator_tb.sv -----
// Self-checking bench for the block allocator: request driver, result monitor, shadow store.
`default_nettype none
module refcounted_block_allocator_tb;

	localparam int NBLK      = 1024;
	localparam int MAXB      = 64;
	localparam int REF_MAX   = 65535;
	localparam int LIMIT     = 600000;
	localparam logic [1:0] REQ_NONE = 2'd3;

	typedef struct packed {
		logic [1:0] req;
		logic [6:0] cnt;
		logic [9:0] idx;
		logic       last;
	} req_item_t;

	typedef struct packed {
		logic [2:0] st;
		logic [9:0] blk;
		logic       has;
		logic       last;
	} rsp_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] req_type = '0;
	logic [6:0] alloc_count = '0;
	logic [9:0] block_index = '0;
	logic batch_last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [9:0] out_block;
	logic has_block;
	logic run_last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [10:0] blocks_in_use = '0;

	refcounted_block_allocator dut (
		.clk, .arst_n, .in_valid, .in_stall, .req_type, .alloc_count, .block_index,
		.batch_last, .out_valid, .out_stall, .status, .out_block, .has_block, .run_last,
		.cfg_valid, .cfg_ready, .blocks_in_use
	);

	always #5 clk = ~clk;

	req_item_t pending_reqs[$];
	rsp_item_t expected_rsps[$];
	int errors = 0;
	int send_idle = 0;
	int recv_idle = 0;
	int hold_left = 0;
	int cycles = 0;

	// shadow allocator state
	int unsigned shadow_blocks;
	logic [9:0]  free_stk[NBLK];
	int unsigned free_top;
	int unsigned refcnt[NBLK];
	int unsigned tally[NBLK];
	logic [9:0]  batch_buf[MAXB];
	int unsigned batch_n;

	function automatic void store_init(int unsigned nb);
		shadow_blocks = nb;
		for (int i = 0; i < NBLK; i++) begin
			free_stk[i] = (i < nb) ? 10'(nb - 1 - i) : 10'd0;
			refcnt[i] = 0;
			tally[i] = 0;
		end
		free_top = nb;
		batch_n = 0;
	endfunction

	function automatic void push_rsp(logic [2:0] st, logic [9:0] blk, logic has, logic last);
		rsp_item_t r;
		r.st = st;
		r.blk = has ? blk : 10'd0;
		r.has = has;
		r.last = last;
		expected_rsps.insert(expected_rsps.size(), r);
	endfunction

	function automatic logic [2:0] check_incref(output logic [9:0] who);
		logic [9:0] b;
		for (int i = 0; i < batch_n; i++) begin
			b = batch_buf[i];
			who = b;
			if (b >= shadow_blocks) return rba_pkg::ST_BAD_ID;
			if (refcnt[b] == 0) return rba_pkg::ST_INCREF_FREE;
		end
		for (int i = 0; i < batch_n; i++) tally[batch_buf[i]]++;
		for (int i = 0; i < batch_n; i++) begin
			b = batch_buf[i];
			if (refcnt[b] + tally[b] > REF_MAX) begin
				who = b;
				for (int j = 0; j < batch_n; j++) tally[batch_buf[j]] = 0;
				return rba_pkg::ST_REF_OVERFLOW;
			end
		end
		for (int i = 0; i < batch_n; i++) tally[batch_buf[i]] = 0;
		for (int i = 0; i < batch_n; i++) refcnt[batch_buf[i]]++;
		return rba_pkg::ST_OK;
	endfunction

	function automatic logic [2:0] check_free(output logic [9:0] who);
		logic [9:0] b;
		for (int i = 0; i < batch_n; i++) begin
			who = batch_buf[i];
			if (batch_buf[i] >= shadow_blocks) return rba_pkg::ST_BAD_ID;
		end
		for (int i = 0; i < batch_n; i++) tally[batch_buf[i]]++;
		for (int i = 0; i < batch_n; i++) begin
			b = batch_buf[i];
			if (refcnt[b] < tally[b]) begin
				who = b;
				for (int j = 0; j < batch_n; j++) tally[batch_buf[j]] = 0;
				return rba_pkg::ST_OVER_RELEASE;
			end
		end
		for (int i = 0; i < batch_n; i++) tally[batch_buf[i]] = 0;
		for (int i = 0; i < batch_n; i++) begin
			b = batch_buf[i];
			refcnt[b]--;
			if (refcnt[b] == 0 && free_top < NBLK) begin
				free_stk[free_top] = b;
				free_top++;
			end
		end
		return rba_pkg::ST_OK;
	endfunction

	function automatic void predict_request(req_item_t it);
		logic [9:0] who;
		logic [9:0] b;
		logic [2:0] st;
		who = '0;
		if (it.req == rba_pkg::REQ_ALLOC) begin
			if (it.cnt == 0) push_rsp(rba_pkg::ST_OK, '0, 1'b0, 1'b1);
			else if (it.cnt > MAXB) push_rsp(rba_pkg::ST_TOO_LONG, '0, 1'b0, 1'b1);
			else if (it.cnt > free_top) push_rsp(rba_pkg::ST_OUT_OF_BLOCKS, '0, 1'b0, 1'b1);
			else begin
				for (int i = 0; i < it.cnt; i++) begin
					free_top--;
					b = free_stk[free_top];
					refcnt[b] = 1;
					push_rsp(rba_pkg::ST_OK, b, 1'b1, (i + 1 == it.cnt));
				end
			end
			return;
		end
		if (it.req == REQ_NONE) return;
		if (batch_n < MAXB) batch_buf[batch_n] = it.idx;
		if (batch_n <= MAXB) batch_n++;
		if (!it.last) return;
		if (batch_n > MAXB) begin
			batch_n = 0;
			push_rsp(rba_pkg::ST_TOO_LONG, '0, 1'b0, 1'b1);
			return;
		end
		st = (it.req == rba_pkg::REQ_INCREF) ? check_incref(who) : check_free(who);
		batch_n = 0;
		push_rsp(st, who, st != rba_pkg::ST_OK, 1'b1);
	endfunction

	// request driver
	always @(posedge clk) begin
		req_item_t cur;
		logic fire;
		logic nv;
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
		fire = in_valid && !in_stall;
		if (fire) begin
			cur = '{req_type, alloc_count, block_index, batch_last};
			predict_request(cur);
		end
		nv = in_valid && !fire;
		if (!nv && arst_n && pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
			cur = pending_reqs.pop_front();
			req_type <= cur.req;
			alloc_count <= cur.cnt;
			block_index <= cur.idx;
			batch_last <= cur.last;
			nv = 1'b1;
		end
		in_valid <= nv;
	end

	// result monitor
	always @(posedge clk) begin
		rsp_item_t e;
		if (out_valid && !out_stall) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected result st=%0d blk=%0d has=%0d last=%0d",
					$time, status, out_block, has_block, run_last);
				errors++;
			end else begin
				e = expected_rsps.pop_front();
				if (e != {status, out_block, has_block, run_last}) begin
					$display("%0t: mismatch exp st=%0d blk=%0d has=%0d last=%0d, act st=%0d blk=%0d has=%0d last=%0d",
						$time, e.st, e.blk, e.has, e.last,
						status, out_block, has_block, run_last);
					errors++;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_idle);
	end

	task automatic add(logic [1:0] r, logic [6:0] c, logic [9:0] i, logic l);
		req_item_t it;
		it = '{r, c, i, l};
		pending_reqs.insert(pending_reqs.size(), it);
	endtask

	task automatic settle();
		while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
			@(posedge clk);
		// trailing non-final items produce nothing; give the sequencer time to finish them
		repeat (100) @(posedge clk);
	endtask

	task automatic write_cfg(logic [10:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		blocks_in_use <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		store_init((v == 0) ? 1 : (v > NBLK) ? NBLK : v);
	endtask

	// random well-formed traffic over low ids, with some bad ids and noise
	task automatic random_phase(int n_items);
		int made;
		int len;
		logic [1:0] kind;
		logic [9:0] id;
		int span;
		made = 0;
		span = (shadow_blocks < 48) ? shadow_blocks + 2 : 48;
		while (made < n_items) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					case ($urandom_range(19))
						0: add(rba_pkg::REQ_ALLOC, 7'd0, 10'($urandom), 1'($urandom));
						1: add(rba_pkg::REQ_ALLOC, 7'($urandom_range(65, 127)), 10'($urandom),
							1'($urandom));
						2: add(rba_pkg::REQ_ALLOC, 7'd64, 10'($urandom), 1'($urandom));
						default: add(rba_pkg::REQ_ALLOC, 7'($urandom_range(1, 6)), 10'($urandom),
							1'($urandom));
					endcase
					made++;
				end
				9: begin
					add(REQ_NONE, 7'($urandom), 10'($urandom), 1'($urandom));
				end
				default: begin
					kind = ($urandom_range(1)) ? rba_pkg::REQ_INCREF : rba_pkg::REQ_FREE;
					len = $urandom_range(1, 5);
					for (int k = 0; k < len; k++) begin
						if ($urandom_range(29) == 0) id = 10'($urandom);
						else id = 10'($urandom_range(span - 1));
						add(($urandom_range(4) == 0) ? rba_pkg::REQ_INCREF : kind, 7'($urandom),
							id, k == len - 1);
						made++;
					end
				end
			endcase
		end
	endtask

	initial begin
		store_init(NBLK);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed part on a tiny store
		write_cfg(11'd4);
		send_idle = 21;
		recv_idle = 65;
		add(rba_pkg::REQ_ALLOC, 7'd0, 10'd0, 1'b0);
		add(rba_pkg::REQ_ALLOC, 7'd65, 10'd0, 1'b0);
		add(rba_pkg::REQ_ALLOC, 7'd127, 10'd1023, 1'b1);
		add(rba_pkg::REQ_ALLOC, 7'd5, 10'd0, 1'b0);
		add(rba_pkg::REQ_ALLOC, 7'd4, 10'd0, 1'b0);
		add(rba_pkg::REQ_ALLOC, 7'd1, 10'd0, 1'b0);
		add(rba_pkg::REQ_INCREF, 7'd0, 10'd0, 1'b0);
		add(rba_pkg::REQ_INCREF, 7'd0, 10'd1, 1'b1);
		add(rba_pkg::REQ_INCREF, 7'd0, 10'd5, 1'b1);
		add(rba_pkg::REQ_FREE, 7'd0, 10'd1023, 1'b1);
		add(rba_pkg::REQ_FREE, 7'd0, 10'd0, 1'b0);
		add(rba_pkg::REQ_FREE, 7'd0, 10'd0, 1'b0);
		add(rba_pkg::REQ_FREE, 7'd0, 10'd0, 1'b1);
		add(rba_pkg::REQ_FREE, 7'd0, 10'd0, 1'b0);
		add(rba_pkg::REQ_FREE, 7'd127, 10'd0, 1'b1);
		add(rba_pkg::REQ_INCREF, 7'd0, 10'd0, 1'b1);
		add(REQ_NONE, 7'd127, 10'd1023, 1'b1);
		add(rba_pkg::REQ_FREE, 7'd0, 10'd1, 1'b0);
		add(rba_pkg::REQ_ALLOC, 7'd1, 10'd0, 1'b0);
		add(rba_pkg::REQ_INCREF, 7'd0, 10'd2, 1'b0);
		add(rba_pkg::REQ_FREE, 7'd0, 10'd2, 1'b1);
		add(rba_pkg::REQ_ALLOC, 7'd2, 10'd0, 1'b0);
		// overlong batch
		for (int k = 0; k < MAXB + 2; k++) add(rba_pkg::REQ_FREE, 7'd0, 10'd3, k == MAXB + 1);
		add(rba_pkg::REQ_FREE, 7'd0, 10'd3, 1'b1);
		settle();

		// register low extreme: clamps to a single block
		write_cfg(11'd0);
		add(rba_pkg::REQ_ALLOC, 7'd1, 10'd0, 1'b0);
		add(rba_pkg::REQ_ALLOC, 7'd1, 10'd0, 1'b0);
		add(rba_pkg::REQ_FREE, 7'd0, 10'd0, 1'b1);
		add(rba_pkg::REQ_ALLOC, 7'd1, 10'd0, 1'b0);
		settle();

		// register high extreme, full store, long hold-off on the output
		write_cfg(11'd2047);
		add(rba_pkg::REQ_ALLOC, 7'd64, 10'd0, 1'b0);
		add(rba_pkg::REQ_ALLOC, 7'd64, 10'd0, 1'b0);
		hold_left = 600;
		random_phase(50);
		settle();

		send_idle = 65;
		recv_idle = 21;
		write_cfg(11'($urandom_range(2, 40)));
		random_phase(50);
		settle();

		send_idle = 0;
		recv_idle = 0;
		write_cfg(11'd1024);
		random_phase(50);
		settle();

		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire
